// ===== design/e2d_pkg.sv =====
package e2d_pkg;

  localparam logic [14:0] ExpAllOnes = 15'h7FFF;
  localparam logic [10:0] DblExpMax  = 11'h7FF;
  localparam int          ExpShift   = 15360;

  // count leading zeros of a 64-bit word, log-depth priority search
  function automatic logic [6:0] clz64(input logic [63:0] v);
    logic [6:0] n;
    logic [63:0] t;
    n = 7'd0;
    t = v;
    if (t[63:32] == 32'd0) begin n = n + 7'd32; t = {t[31:0], 32'd0}; end
    if (t[63:48] == 16'd0) begin n = n + 7'd16; t = {t[47:0], 16'd0}; end
    if (t[63:56] == 8'd0)  begin n = n + 7'd8;  t = {t[55:0], 8'd0};  end
    if (t[63:60] == 4'd0)  begin n = n + 7'd4;  t = {t[59:0], 4'd0};  end
    if (t[63:62] == 2'd0)  begin n = n + 7'd2;  t = {t[61:0], 2'd0};  end
    if (t[63] == 1'b0)     begin n = n + 7'd1; end
    if (v == 64'd0) n = 7'd64;
    return n;
  endfunction

endpackage

// ===== design/extended80_to_double_converter_core.sv =====
// Converts an 80-bit extended value (sign/exponent word plus explicit
// 64-bit significand) into an IEEE binary64 bit pattern, rounded once to
// nearest even, with overflow to infinity and gradual underflow. All-ones
// exponents (infinity or any NaN) give a signed infinity. Four register
// stages: classify and leading-zero count, normalise shift and exponent,
// round, output register. One item per cycle unless the output stalls;
// the result is valid once the item reaches the output register. A stall
// holds every stage that carries an item; no item is lost or repeated.
module extended80_to_double_converter_core
  import e2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sign_and_exponent_i,
  input  logic [63:0] mantissa_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] double_bits_o
);

  // stage enables: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1
  logic        s1_sign_q;
  logic        s1_spec_q;   // infinity or zero, bypasses arithmetic
  logic [62:0] s1_spec_mag_q;
  logic [14:0] s1_exp_q;
  logic [63:0] s1_man_q;
  logic [6:0]  s1_lz_q;

  // stage 2
  logic        s2_sign_q;
  logic        s2_spec_q;
  logic [62:0] s2_spec_mag_q;
  logic [63:0] s2_norm_q;
  logic        s2_ovf_q;
  logic        s2_denorm_q;
  logic [6:0]  s2_shift_q;
  logic [10:0] s2_exp_field_q;

  // stage 3
  logic        s3_sign_q;
  logic [62:0] s3_mag_q;

  logic [63:0] out_q;

  logic signed [17:0] de;
  logic signed [17:0] sh;
  logic [62:0]        round_mag;

  always_comb begin
    de = signed'({3'd0, s1_exp_q}) - 18'sd15360 - signed'({11'd0, s1_lz_q});
    sh = 18'sd12 - de;
  end

  e2d_round u_round (
    .norm_i     (s2_norm_q),
    .shift_i    (s2_shift_q),
    .denorm_i   (s2_denorm_q),
    .exp_field_i(s2_exp_field_q),
    .mag_o      (round_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sign_q     <= sign_and_exponent_i[15];
      s1_exp_q      <= sign_and_exponent_i[14:0];
      s1_man_q      <= mantissa_i;
      s1_lz_q       <= clz64(mantissa_i);
      s1_spec_q     <= (sign_and_exponent_i[14:0] == ExpAllOnes) || (mantissa_i == 64'd0);
      s1_spec_mag_q <= (sign_and_exponent_i[14:0] == ExpAllOnes) ?
                       {DblExpMax, 52'd0} : 63'd0;
    end
    if (en2) begin
      s2_sign_q      <= s1_sign_q;
      s2_spec_q      <= s1_spec_q;
      s2_spec_mag_q  <= s1_spec_mag_q;
      s2_norm_q      <= s1_man_q << s1_lz_q[5:0];
      s2_ovf_q       <= de >= 18'sd2047;
      s2_denorm_q    <= de < 18'sd1;
      s2_exp_field_q <= (de >= 18'sd1) ? 11'(de - 18'sd1) : 11'd0;
      if (de >= 18'sd1)       s2_shift_q <= 7'd11;
      else if (sh > 18'sd65)  s2_shift_q <= 7'd65;
      else                    s2_shift_q <= 7'(sh);
    end
    if (en3) begin
      s3_sign_q <= s2_sign_q;
      if (s2_spec_q)     s3_mag_q <= s2_spec_mag_q;
      else if (s2_ovf_q) s3_mag_q <= {DblExpMax, 52'd0};
      else               s3_mag_q <= round_mag;
    end
    if (en4) out_q <= {s3_sign_q, s3_mag_q};
  end

  assign out_valid_o   = v4_q;
  assign double_bits_o = out_q;

endmodule

// ===== design/e2d_round.sv =====
// final rounding stage: shifts the normalised significand into place and
// rounds to nearest even
module e2d_round
  import e2d_pkg::*;
(
  input  logic [63:0] norm_i,
  input  logic [6:0]  shift_i,
  input  logic        denorm_i,
  input  logic [10:0] exp_field_i,
  output logic [62:0] mag_o
);

  logic [63:0] q;
  logic        half;
  logic        rest;
  logic [63:0] below;
  logic [63:0] sticky_mask;
  logic [63:0] rounded;

  always_comb begin
    // shift_i runs 11..65; 65 means everything is shifted out
    q           = 64'd0;
    half        = 1'b0;
    sticky_mask = 64'd0;
    if (shift_i <= 7'd64) begin
      q           = (shift_i == 7'd64) ? 64'd0 : (norm_i >> shift_i[5:0]);
      half        = norm_i[6'(shift_i - 7'd1)];
      sticky_mask = (64'd1 << 6'(shift_i - 7'd1)) - 64'd1;
    end
    below   = norm_i & sticky_mask;
    rest    = |below;
    rounded = q + {63'd0, half & (rest | q[0])};
    if (denorm_i) mag_o = rounded[62:0];
    else          mag_o = {1'b0, 62'd0} + ({exp_field_i, 52'd0} + rounded[62:0]);
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import e2d_pkg::*;

  localparam int NumRandom   = 450;
  localparam int IdleLimit   = 20000;
  localparam int LatencyTail = 12;
  localparam logic [63:0] DblInf = 64'h7FF0_0000_0000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] sign_and_exponent_i;
  logic [63:0] mantissa_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] double_bits_o;

  extended80_to_double_converter_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sign_and_exponent_i(sign_and_exponent_i),
    .mantissa_i         (mantissa_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .double_bits_o      (double_bits_o)
  );

  typedef struct {
    logic [15:0] se;
    logic [63:0] man;
    logic        known;
    logic [63:0] dbl;
  } conv_row_t;

  logic [63:0] expected_doubles[$];
  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  idle_cycles;
  bit  quiet_phase;
  bit  hold_off;
  bit  sending_done;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // nearest-even right shift, s >= 1
  function automatic logic [63:0] round_shift(input logic [63:0] v, input int s);
    logic [63:0] q;
    logic        half;
    logic        rest;
    if (s > 64) return 64'd0;
    if (s == 64) begin
      q    = 64'd0;
      half = v[63];
      rest = |v[62:0];
    end else begin
      q    = v >> s;
      half = v[s-1];
      rest = |(v & ((64'd1 << (s - 1)) - 64'd1));
    end
    if (half && (rest || q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [63:0] extended_to_double(input logic [15:0] se,
                                                     input logic [63:0] man);
    logic [63:0] mag;
    logic [63:0] norm;
    int          lz;
    int          dexp;
    int          s;
    if (se[14:0] == ExpAllOnes) begin
      mag = DblInf;
    end else if (man == 64'd0) begin
      mag = 64'd0;
    end else begin
      lz = 0;
      norm = man;
      while (!norm[63]) begin
        norm = norm << 1;
        lz++;
      end
      dexp = int'(se[14:0]) - ExpShift - lz;
      if (dexp >= 2047) begin
        mag = DblInf;
      end else if (dexp >= 1) begin
        // rounding carry walks into the exponent, may reach infinity
        mag = (64'(dexp - 1) << 52) + round_shift(norm, 11);
      end else begin
        s = 12 - dexp;
        mag = round_shift(norm, (s > 65) ? 65 : s);
      end
    end
    return {se[15], 63'd0} | mag;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch: %s got %016h want %016h", what, got, want);
  endtask

  task automatic send_item(input logic [15:0] se, input logic [63:0] man,
                           input bit known, input logic [63:0] dbl);
    logic [63:0] want;
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    want = extended_to_double(se, man);
    if (known && want !== dbl) report_mismatch("directed row", want, dbl);
    in_valid_i          <= 1'b1;
    sign_and_exponent_i <= se;
    mantissa_i          <= man;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_doubles.push_back(known ? dbl : want);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_mantissa();
    logic [63:0] m;
    m = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: m = m >> $urandom_range(1, 63);
      1: m = {1'b1, 52'd0, m[10:0]};        // near tie of the rounding
      2: m = {1'b1, m[62:11], 1'b1, 10'd0};
      3: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m[63] = 1'b1;
    endcase
    return m;
  endfunction

  function automatic logic [14:0] random_exponent();
    case ($urandom_range(0, 5))
      0: return 15'($urandom_range(0, 32767));
      1: return 15'($urandom_range(15360 - 70, 15360 + 3));   // denormal edge
      2: return 15'($urandom_range(15360 + 2040, 15360 + 2050)); // overflow edge
      3: return ExpAllOnes;
      default: return 15'($urandom_range(15300, 17500));
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_doubles.size() == 0) begin
        report_mismatch("unexpected item", double_bits_o, 64'd0);
      end else begin
        want = expected_doubles.pop_front();
        if (double_bits_o !== want) report_mismatch("double_bits", double_bits_o, want);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (!sending_done || expected_doubles.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d items outstanding", expected_doubles.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    conv_row_t rows[$];
    int tail;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    quiet_phase  = 1'b0;
    hold_off     = 1'b0;
    sending_done = 1'b0;
    in_valid_i          = 1'b0;
    sign_and_exponent_i = 16'd0;
    mantissa_i          = 64'd0;
    rst_ni = 1'b0;

    rows = '{
      '{16'h0000, 64'd0, 1'b1, 64'd0},
      '{16'h8000, 64'd0, 1'b1, 64'h8000_0000_0000_0000},
      '{16'h4000, 64'd0, 1'b1, 64'd0},
      '{16'h7FFF, 64'h8000_0000_0000_0000, 1'b1, DblInf},
      '{16'hFFFF, 64'h8000_0000_0000_0000, 1'b1, 64'hFFF0_0000_0000_0000},
      '{16'h7FFF, 64'hC000_0000_0000_0001, 1'b1, DblInf},
      '{16'hFFFF, 64'd0, 1'b1, 64'hFFF0_0000_0000_0000},
      '{16'h3FFF, 64'h8000_0000_0000_0000, 1'b1, 64'h3FF0_0000_0000_0000},
      '{16'hBFFF, 64'h8000_0000_0000_0000, 1'b1, 64'hBFF0_0000_0000_0000},
      '{16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, DblInf},
      '{16'h43FE, 64'hFFFF_FFFF_FFFF_F800, 1'b1, 64'h7FEF_FFFF_FFFF_FFFF},
      '{16'h43FE, 64'hFFFF_FFFF_FFFF_FC00, 1'b1, DblInf},
      '{16'h3C01, 64'h8000_0000_0000_0000, 1'b1, 64'h0010_0000_0000_0000},
      '{16'h3BCD, 64'h8000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0001},
      '{16'h3BCC, 64'h8000_0000_0000_0000, 1'b1, 64'd0},
      '{16'h3BCC, 64'h8000_0000_0000_0001, 1'b1, 64'h0000_0000_0000_0001},
      '{16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0},
      '{16'h3FFF, 64'h0000_0000_0000_0001, 1'b0, 64'd0},
      '{16'h3FFF, 64'h4000_0000_0000_0000, 1'b0, 64'd0},
      '{16'h0000, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
      '{16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
      '{16'h3FFF, 64'h8000_0000_0000_0400, 1'b0, 64'd0},
      '{16'h3FFF, 64'h8000_0000_0000_0C00, 1'b0, 64'd0},
      '{16'hC123, 64'hAAAA_5555_AAAA_5555, 1'b0, 64'd0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_item(rows[i].se, rows[i].man, rows[i].known, rows[i].dbl);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 150) hold_off = 1'b1;
      if (n == NumRandom - 60) quiet_phase = 1'b1;
      send_item({1'($urandom_range(0, 1)), random_exponent()}, random_mantissa(),
                1'b0, 64'd0);
    end
    in_valid_i   <= 1'b0;
    sending_done = 1'b1;

    while (expected_doubles.size() != 0) @(posedge clk_i);
    tail = 0;
    while (tail < LatencyTail) begin
      @(posedge clk_i);
      tail++;
    end

    $display("converted %0d extended values, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("covered zeros, infinities and NaNs, unnormals, overflow and denormal rounding");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
